/* sv/sddm_pkg.sv */
// shared types and constants of the serial differential drive mixer
package sddm_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MIX_W    = 14;
    localparam int unsigned WIDE_W   = 16;
    localparam int unsigned DRIVE_W  = 11;
    localparam int unsigned DBAND_W  = 13;
    localparam int unsigned BOOST_W  = 10;
    localparam int unsigned LIMIT_W  = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 13;

    typedef logic [BYTE_W-1:0]         t_byte;
    typedef logic signed [MIX_W-1:0]   t_mix;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [DRIVE_W-1:0] t_drive;

    // command bytes
    localparam t_byte CMD_START = 8'h73;
    localparam t_byte CMD_FRAME = 8'h63;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd2;

    // configuration reset values
    localparam logic [DBAND_W-1:0] DEADBAND_RST    = 13'd100;
    localparam logic [BOOST_W-1:0] BOOST_RST       = 10'd300;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 10'd1023;

endpackage

/* sv/serial_differential_drive_mixer.sv */
// top level of the serial differential drive mixer
//
// usage:
// - input channel: one received serial byte per item on i_rx_byte, taken at an
//   edge with i_in_valid high and o_in_stall low
// - output channel: exactly one result item per input item, offered on
//   o_out_valid and taken at an edge with i_out_stall low
// - the byte stream is a start byte, then commands; a frame command opens three
//   signed bytes (unused, steering, throttle); any other command halts the motors
// - the throttle byte yields left and right drive with o_update set; right drive
//   comes out negated; drives read zero on every other item
// - path: an accepted item goes through the input register, then the result
//   register, which drives the outputs
// - throughput: one item per cycle while the receiver does not stall; the work
//   between the registers is the mix sum, the deadband compare, boost and clamp
// - receiver stall: the result register holds, an empty input register still
//   takes one more item, then o_in_stall rises until the result is taken
// - configuration: registers deadband, boost, speed_limit, always-ready port;
//   the user must write them only while no item is in flight; not enforced here
// - reset (synchronous, active low): pipeline empty, phase back to waiting for
//   the start byte, registers at 100, 300 and 1023
module serial_differential_drive_mixer
    import sddm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DRIVE_W-1:0]    o_left_drive,
    output logic [DRIVE_W-1:0]    o_right_drive,
    output logic                  o_update,
    output logic                  o_halt,
    output logic                  o_send_ready,
    // configuration write port
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // phase codes
    localparam logic [2:0] PH_WAIT_START = 3'd0;
    localparam logic [2:0] PH_WAIT_CMD   = 3'd1;
    localparam logic [2:0] PH_UNUSED     = 3'd2;
    localparam logic [2:0] PH_STEER      = 3'd3;
    localparam logic [2:0] PH_THROTTLE   = 3'd4;

    // configuration registers
    logic [DBAND_W-1:0] r_deadband;
    logic [BOOST_W-1:0] r_boost;
    logic [LIMIT_W-1:0] r_speed_limit;

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // parser state
    logic [2:0] r_phase;
    logic [2:0] n_phase;
    t_byte      r_steer_byte;
    t_byte      n_steer_byte;

    // result register
    logic   r_out_valid;
    t_drive r_left;
    t_drive r_right;
    logic   r_update;
    logic   r_halt;
    logic   r_send_ready;

    // next result values
    t_drive n_left;
    t_drive n_right;
    logic   n_update;
    logic   n_halt;
    logic   n_send_ready;

    // handshake
    logic w_out_free;
    logic w_in_acc;
    logic w_fire;

    // mixing
    t_mix   w_steer;
    t_mix   w_throttle;
    t_mix   w_left_mix;
    t_mix   w_right_mix;
    t_drive w_left_shape;
    t_drive w_right_shape;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband    <= DEADBAND_RST;
            r_boost       <= BOOST_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEADBAND:    r_deadband    <= i_cfg_wdata[DBAND_W-1:0];
                REG_BOOST:       r_boost       <= i_cfg_wdata[BOOST_W-1:0];
                REG_SPEED_LIMIT: r_speed_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;  // index beyond the register list is dropped
            endcase
        end
    end

    // result register frees when empty or being taken
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_fire     = r_in_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // mix throttle and latched steering, times sixteen
    assign w_steer     = {{(MIX_W-BYTE_W){r_steer_byte[BYTE_W-1]}}, r_steer_byte};
    assign w_throttle  = {{(MIX_W-BYTE_W){r_in_byte[BYTE_W-1]}}, r_in_byte};
    assign w_left_mix  = (w_throttle + w_steer) <<< 4;
    assign w_right_mix = (w_throttle - w_steer) <<< 4;

    sddm_shape u_shape_left (
        .i_mix      (w_left_mix),
        .i_deadband (r_deadband),
        .i_boost    (r_boost),
        .i_limit    (r_speed_limit),
        .o_drive    (w_left_shape)
    );

    sddm_shape u_shape_right (
        .i_mix      (w_right_mix),
        .i_deadband (r_deadband),
        .i_boost    (r_boost),
        .i_limit    (r_speed_limit),
        .o_drive    (w_right_shape)
    );

    // byte parser, one step per item leaving the input register
    always_comb begin
        n_phase      = r_phase;
        n_steer_byte = r_steer_byte;
        n_left       = '0;
        n_right      = '0;
        n_update     = 1'b0;
        n_halt       = 1'b0;
        n_send_ready = 1'b0;
        unique case (r_phase)
            PH_WAIT_CMD: begin
                if (r_in_byte == CMD_FRAME) begin
                    n_phase = PH_UNUSED;
                end else begin
                    // stop command: motors off, prompt again
                    n_halt       = 1'b1;
                    n_send_ready = 1'b1;
                end
            end
            PH_UNUSED: begin
                n_phase = PH_STEER;
            end
            PH_STEER: begin
                n_steer_byte = r_in_byte;
                n_phase      = PH_THROTTLE;
            end
            PH_THROTTLE: begin
                n_left       = w_left_shape;
                n_right      = -w_right_shape;
                n_update     = 1'b1;
                n_send_ready = 1'b1;
                n_phase      = PH_WAIT_CMD;
            end
            default: begin
                // waiting for start; unreachable codes fall here too
                if (r_in_byte == CMD_START) begin
                    n_send_ready = 1'b1;
                    n_phase      = PH_WAIT_CMD;
                end else begin
                    n_phase = PH_WAIT_START;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT_START;
            r_steer_byte <= '0;
        end else if (w_fire) begin
            r_phase      <= n_phase;
            r_steer_byte <= n_steer_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (w_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_left       <= n_left;
            r_right      <= n_right;
            r_update     <= n_update;
            r_halt       <= n_halt;
            r_send_ready <= n_send_ready;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;
    assign o_update      = r_update;
    assign o_halt        = r_halt;
    assign o_send_ready  = r_send_ready;

`ifndef SYNTHESIS
    // a frame result and a stop result never coincide
    a_upd_halt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_update && o_halt))
        else $error("update and halt both set");

    // drives read zero outside a frame result
    a_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_update) |-> (o_left_drive == '0 && o_right_drive == '0))
        else $error("nonzero drive without update");

    // every completed frame prompts for the next command
    a_upd_prompt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_update) |-> o_send_ready)
        else $error("frame result without ready prompt");

    // parser never leaves the defined phases
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_THROTTLE)
        else $error("parser phase out of range");

    // a held result and a full input register push back on the sender
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_in_valid) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost an item under stall");
`endif

endmodule

/* sv/sddm_shape.sv */
// deadband, boost and saturation of one mixed drive value
module sddm_shape
    import sddm_pkg::*;
(
    input  t_mix               i_mix,
    input  logic [DBAND_W-1:0] i_deadband,
    input  logic [BOOST_W-1:0] i_boost,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_drive             o_drive
);

    t_wide w_m;
    t_wide w_db;
    t_wide w_b;
    t_wide w_lim;
    t_wide w_up;
    t_wide w_dn;
    t_wide w_dead;
    t_wide w_sat;
    logic  w_inside;

    assign w_m   = {{(WIDE_W-MIX_W){i_mix[MIX_W-1]}}, i_mix};
    assign w_db  = {{(WIDE_W-DBAND_W){1'b0}}, i_deadband};
    assign w_b   = {{(WIDE_W-BOOST_W){1'b0}}, i_boost};
    assign w_lim = {{(WIDE_W-LIMIT_W){1'b0}}, i_limit};

    // zero deadband: a zero value gets pushed up, never back down
    assign w_inside = (w_m < w_db) && (w_m > -w_db);
    assign w_up     = (w_m >= w_db) ? (w_m + w_b) : w_m;
    assign w_dn     = (w_up <= -w_db) ? (w_up - w_b) : w_up;
    assign w_dead   = w_inside ? '0 : w_dn;

    always_comb begin
        w_sat = w_dead;
        if (w_dead > w_lim) begin
            w_sat = w_lim;
        end
        if (w_dead < -w_lim) begin
            w_sat = -w_lim;
        end
    end

    assign o_drive = w_sat[DRIVE_W-1:0];

endmodule

/* tb/sddm_checker.sv */
// result checker for the serial differential drive mixer: predicts every result and compares
module sddm_checker
    import sddm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [DRIVE_W-1:0]    i_left_drive,
    input  logic [DRIVE_W-1:0]    i_right_drive,
    input  logic                  i_update,
    input  logic                  i_halt,
    input  logic                  i_send_ready,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_errors,
    output int                    o_pending
);

    typedef enum logic [2:0] {
        PH_WAIT_START = 3'd0,
        PH_WAIT_CMD   = 3'd1,
        PH_SKIP       = 3'd2,
        PH_STEER      = 3'd3,
        PH_THROTTLE   = 3'd4
    } t_phase;

    typedef struct packed {
        t_drive left;
        t_drive right;
        logic   update;
        logic   halt;
        logic   send_ready;
    } t_drive_result;

    t_drive_result       drive_q[$];
    logic [DBAND_W-1:0]  deadband;
    logic [BOOST_W-1:0]  boost;
    logic [LIMIT_W-1:0]  speed_limit;
    t_phase              phase;
    t_byte               steer_latch;
    int                  err_count;

    // deadband, boost away from zero, then clamp to +-speed_limit
    function automatic int shape_drive(input int mixed);
        int db;
        int lim;
        int m;
        db  = int'(deadband);
        lim = int'(speed_limit);
        m   = mixed;
        if (m < db && m > -db) begin
            m = 0;
        end else begin
            if (m >= db) m = m + int'(boost);
            if (m <= -db) m = m - int'(boost);
        end
        if (m > lim) m = lim;
        if (m < -lim) m = -lim;
        return m;
    endfunction

    // advances the byte parser and returns the result of one byte
    function automatic t_drive_result next_result(input t_byte b);
        t_drive_result r;
        int steer;
        int throttle;
        r = '0;
        case (phase)
            PH_WAIT_CMD: begin
                if (b == CMD_FRAME) begin
                    phase = PH_SKIP;
                end else begin
                    r.halt       = 1'b1;
                    r.send_ready = 1'b1;
                end
            end
            PH_SKIP: phase = PH_STEER;
            PH_STEER: begin
                steer_latch = b;
                phase = PH_THROTTLE;
            end
            PH_THROTTLE: begin
                steer    = int'($signed(steer_latch));
                throttle = int'($signed(b));
                r.left       = t_drive'(shape_drive(16 * throttle + 16 * steer));
                r.right      = t_drive'(-shape_drive(16 * throttle - 16 * steer));
                r.update     = 1'b1;
                r.send_ready = 1'b1;
                phase = PH_WAIT_CMD;
            end
            default: begin
                if (b == CMD_START) begin
                    r.send_ready = 1'b1;
                    phase = PH_WAIT_CMD;
                end else begin
                    phase = PH_WAIT_START;
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int expv, input int gotv);
        if (expv != gotv) begin
            err_count++;
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, expv, gotv);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_drive_result expv;
        if (!i_rst_n) begin
            deadband    = DEADBAND_RST;
            boost       = BOOST_RST;
            speed_limit = SPEED_LIMIT_RST;
            phase       = PH_WAIT_START;
            steer_latch = '0;
            err_count   = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEADBAND:    deadband    = i_cfg_wdata[DBAND_W-1:0];
                    REG_BOOST:       boost       = i_cfg_wdata[BOOST_W-1:0];
                    REG_SPEED_LIMIT: speed_limit = i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected result item: expected none, actual one", $time);
                end else begin
                    expv = drive_q.pop_front();
                    check_field("left_drive", int'(expv.left), int'($signed(i_left_drive)));
                    check_field("right_drive", int'(expv.right), int'($signed(i_right_drive)));
                    check_field("update", int'(expv.update), int'(i_update));
                    check_field("halt", int'(expv.halt), int'(i_halt));
                    check_field("send_ready", int'(expv.send_ready), int'(i_send_ready));
                end
            end
            if (i_in_valid && !i_in_stall)
                drive_q.push_back(next_result(i_rx_byte));
        end
        o_errors  <= err_count;
        o_pending <= drive_q.size();
    end

endmodule

/* tb/tb_top.sv */
// top of the mixer testbench: clock, reset, byte stimulus, register settings and verdict
module tb_top;
    import sddm_pkg::*;

    // index outside the register list, written once to show it is ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int ITEMS_PER_SETTING = 72;
    localparam int LONG_HOLD_CYCLES  = 60;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_rx_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [DRIVE_W-1:0]    o_left_drive;
    logic [DRIVE_W-1:0]    o_right_drive;
    logic                  o_update;
    logic                  o_halt;
    logic                  o_send_ready;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int errors;
    int pending;

    // idling rates in percent, per byte for gaps and per cycle for stalls, changed between register settings
    int gap_pct;
    int stall_pct;
    // request for one long receiver hold-off
    int hold_req;

    serial_differential_drive_mixer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive),
        .o_update      (o_update),
        .o_halt        (o_halt),
        .o_send_ready  (o_send_ready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    sddm_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_left_drive  (o_left_drive),
        .i_right_drive (o_right_drive),
        .i_update      (o_update),
        .i_halt        (o_halt),
        .i_send_ready  (o_send_ready),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or loses a result
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // receiver side: short random stall bursts, plus one long hold-off on request
    // so the pipeline fills and the block has to stall its input
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // offer one byte, with a random gap in front, and hold it until taken;
    // valid stays high on return so back-to-back items need no second assignment
    task automatic send_byte(input t_byte b);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // frame command, unused byte, steering, throttle
    task automatic send_frame(input t_byte steer, input t_byte throttle);
        send_byte(CMD_FRAME);
        send_byte(t_byte'($urandom));
        send_byte(steer);
        send_byte(throttle);
    endtask

    // stop command: any byte except the frame command
    function automatic t_byte stop_byte();
        t_byte b;
        b = t_byte'($urandom);
        if (b == CMD_FRAME || $urandom_range(0, 3) == 0) b = CMD_START;
        return b;
    endfunction

    // steering or throttle value: extremes, values around the deadband, or anything
    function automatic t_byte axis_byte();
        t_byte b;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: b = 8'h00;
                    1: b = 8'h7F;
                    2: b = 8'h80;
                    3: b = 8'hFF;
                    default: b = 8'h01;
                endcase
            end
            1: b = t_byte'($urandom_range(0, 16) - 8);
            default: b = t_byte'($urandom);
        endcase
        return b;
    endfunction

    // stop offering and wait until every predicted result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // write all three registers back to back, optionally the unused index too
    task automatic write_regs(input logic [DBAND_W-1:0] db, input logic [BOOST_W-1:0] bst,
                              input logic [LIMIT_W-1:0] lim, input bit touch_unused);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        int n;
        idx[0] = REG_DEADBAND;    val[0] = CFG_DATA_W'(db);
        idx[1] = REG_BOOST;       val[1] = CFG_DATA_W'(bst);
        idx[2] = REG_SPEED_LIMIT; val[2] = CFG_DATA_W'(lim);
        idx[3] = REG_UNUSED;      val[3] = CFG_DATA_W'($urandom);
        n = touch_unused ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_wdata <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [DBAND_W-1:0] db;
        logic [BOOST_W-1:0] bst;
        logic [LIMIT_W-1:0] lim;
        int sent;

        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings: deadband 100, boost 300, limit 1023
        gap_pct   = 20;
        stall_pct = 20;
        // before the start byte everything is ignored, the frame command too
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CMD_FRAME);
        send_byte(CMD_START);
        // stop commands, a repeated start byte among them
        send_byte(CMD_START);
        send_byte(8'hFF);
        // inside the deadband on both sides
        send_frame(8'h00, 8'h00);
        // full forward and full reverse: left saturates, right stays in the deadband
        send_frame(8'h7F, 8'h7F);
        send_frame(8'h80, 8'h80);
        // opposite extremes: left small, right saturated the other way
        send_frame(8'h7F, 8'h80);
        // just above the deadband on the left only
        send_frame(8'h04, 8'h03);

        // register settings; the last one runs without any idling
        for (int ph = 1; ph <= 8; ph++) begin
            drain();
            case (ph)
                1: begin db = '0;       bst = '0;       lim = '0;       end
                2: begin db = '0;       bst = 10'd1023; lim = 10'd1023; end
                3: begin db = 13'd4096; bst = 10'd1023; lim = 10'd1023; end
                4: begin db = 13'd1;    bst = '0;       lim = 10'd1023; end
                5: begin
                    db  = DBAND_W'($urandom_range(2048, 4095));
                    bst = BOOST_W'($urandom);
                    lim = LIMIT_W'($urandom);
                end
                8: begin db = DEADBAND_RST; bst = BOOST_RST; lim = SPEED_LIMIT_RST; end
                default: begin
                    db  = DBAND_W'($urandom_range(0, 600));
                    bst = BOOST_W'($urandom);
                    lim = LIMIT_W'($urandom_range(200, 1023));
                end
            endcase
            write_regs(db, bst, lim, ph == 6);

            if (ph == 8) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            if (ph == 2) hold_req = 1;

            // zero mix: with zero deadband this is boosted upward
            send_frame(8'h00, 8'h00);
            sent = 4;
            // mostly well-formed frames with random content, some stop commands
            while (sent < ITEMS_PER_SETTING) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_frame(axis_byte(), axis_byte());
                    sent += 4;
                end else begin
                    send_byte(stop_byte());
                    sent += 1;
                end
            end
        end

        drain();
        repeat (5) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
sv/sddm_pkg.sv
sv/sddm_shape.sv
sv/serial_differential_drive_mixer.sv
tb/sddm_checker.sv
tb/tb_top.sv
